>>> rtl/sfp_pkg.sv
// Shared types and constants for the serial frame parser.
// Parse phases, result event codes, register indexes and the result record.
// No dependencies.
`default_nettype none

package sfp_pkg;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_USER = 3'd1,
		PH_TYPE = 3'd2,
		PH_LEN  = 3'd3,
		PH_ID   = 3'd4,
		PH_DATA = 3'd5,
		PH_SUM  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_GOOD     = 2'd1,
		EV_BAD_SUM  = 2'd2,
		EV_LEN_FAIL = 2'd3
	} event_t;

	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_USER_ID = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	localparam logic [7:0]  HEADER_RESET  = 8'd165;
	localparam logic [7:0]  USER_ID_RESET = 8'd1;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1016;

	typedef struct packed {
		event_t      kind;
		logic [7:0]  pbyte;
		logic [15:0] pindex;
		logic [7:0]  ftype;
		logic [15:0] fid;
		logic [15:0] plen;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/serial_frame_parser.sv
// Serial frame parser.
// Parses header, user id, type, length, id, payload and checksum bytes.
// Depends on sfp_pkg.
//
// Usage: received bytes enter on in_valid/in_ready with rx_byte, one byte per
// item. Each byte updates the parse state in the cycle it is accepted. A byte
// that causes a result (payload byte, frame good, checksum bad, length
// rejected) is registered as a result item for the out channel. Throughput is
// one byte per cycle while in_ready is high, set by the parse state register.
// The output side has a result register and a one-entry skid register, so the
// block keeps taking bytes while a result waits; in_ready drops only once the
// skid register also holds a result, and returns the cycle after the
// receiver takes one.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and indexes beyond the register list are ignored.
// Asynchronous reset loads the register defaults (header 165, user id 1,
// length limit 1016), returns the parser to waiting for a header and empties
// the output and skid registers.
`default_nettype none

module serial_frame_parser
	import sfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       event_kind,
	output logic [7:0]       payload_byte,
	output logic [15:0]      payload_index,
	output logic [7:0]       frame_type,
	output logic [15:0]      frame_id,
	output logic [15:0]      payload_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [7:0]  header_q;
	logic [7:0]  user_id_q;
	logic [15:0] max_len_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] id_q, id_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;

	logic        res_valid;
	result_t     res;
	logic        accept;
	logic [15:0] len_full;
	logic [15:0] pos_inc;

	logic        out_valid_q;
	result_t     out_q;
	logic        skid_valid_q;
	result_t     skid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign len_full  = {rx_byte, len_q[7:0]};
	assign pos_inc   = pos_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RESET;
			user_id_q <= USER_ID_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEADER:  header_q  <= cfg_data[7:0];
				REG_USER_ID: user_id_q <= cfg_data[7:0];
				REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_WAIT: if (rx_byte == header_q) phase_d = PH_USER;
			PH_USER: phase_d = (rx_byte == user_id_q) ? PH_TYPE : PH_WAIT;
			PH_TYPE: phase_d = PH_LEN;
			PH_LEN: begin
				if (pos_q != 16'd0) begin
					phase_d = (len_full > max_len_q) ? PH_WAIT : PH_ID;
				end
			end
			PH_ID: begin
				if (pos_q != 16'd0) begin
					phase_d = (len_q == 16'd0) ? PH_SUM : PH_DATA;
				end
			end
			PH_DATA: if (pos_inc >= len_q) phase_d = PH_SUM;
			PH_SUM:  phase_d = PH_WAIT;
			default: phase_d = PH_WAIT;
		endcase
	end

	always_comb begin
		type_d    = type_q;
		len_d     = len_q;
		id_d      = id_q;
		pos_d     = pos_q;
		sum_d     = sum_q + rx_byte;
		res_valid = 1'b0;
		res       = '{kind: EV_PAYLOAD, pbyte: 8'd0, pindex: 16'd0,
		              ftype: type_q, fid: id_q, plen: len_q};
		case (phase_q)
			PH_WAIT: begin
				sum_d = sum_q;
				if (rx_byte == header_q) begin
					type_d = 8'd0;
					len_d  = 16'd0;
					id_d   = 16'd0;
					pos_d  = 16'd0;
					sum_d  = rx_byte;
				end
			end
			PH_USER: if (rx_byte != user_id_q) sum_d = sum_q;
			PH_TYPE: begin
				type_d = rx_byte;
				pos_d  = 16'd0;
			end
			PH_LEN: begin
				if (pos_q == 16'd0) begin
					len_d = {8'd0, rx_byte};
					pos_d = 16'd1;
				end else begin
					len_d = len_full;
					pos_d = 16'd0;
					if (len_full > max_len_q) begin
						res_valid = 1'b1;
						res.kind  = EV_LEN_FAIL;
						res.fid   = 16'd0;
						res.plen  = len_full;
					end
				end
			end
			PH_ID: begin
				if (pos_q == 16'd0) begin
					id_d  = {8'd0, rx_byte};
					pos_d = 16'd1;
				end else begin
					id_d  = {rx_byte, id_q[7:0]};
					pos_d = 16'd0;
				end
			end
			PH_DATA: begin
				res_valid  = 1'b1;
				res.pbyte  = rx_byte;
				res.pindex = pos_q;
				pos_d      = pos_inc;
			end
			PH_SUM: begin
				sum_d     = sum_q;
				res_valid = 1'b1;
				res.kind  = ((8'd0 - sum_q) == rx_byte) ? EV_GOOD : EV_BAD_SUM;
			end
			default: sum_d = sum_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			type_q  <= 8'd0;
			len_q   <= 16'd0;
			id_q    <= 16'd0;
			pos_q   <= 16'd0;
			sum_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			id_q    <= id_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = out_q.kind;
	assign payload_byte   = out_q.pbyte;
	assign payload_index  = out_q.pindex;
	assign frame_type     = out_q.ftype;
	assign frame_id       = out_q.fid;
	assign payload_length = out_q.plen;

endmodule

`default_nettype wire

>>> verif/sfp_frame_checker.sv
// Result checker for the serial frame parser: tracks the frame state from the accepted
// bytes and register writes, and compares every result item field by field.
// Depends on sfp_pkg.
`default_nettype none

module sfp_frame_checker
	import sfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  event_kind,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [15:0] payload_index,
	input  wire logic [7:0]  frame_type,
	input  wire logic [15:0] frame_id,
	input  wire logic [15:0] payload_length,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               outstanding,
	output int               results_seen
);

	logic [7:0]  hdr_reg;
	logic [7:0]  uid_reg;
	logic [15:0] max_len_reg;

	phase_t      phase;
	logic [7:0]  cur_type;
	logic [15:0] cur_len;
	logic [15:0] cur_id;
	logic [15:0] pos;
	logic [7:0]  sum;

	result_t expected_events[$];

	task automatic flag_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t: %s got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic queue_event(input event_t kind, input logic [7:0] pb,
			input logic [15:0] pi, input logic [15:0] fid);
		result_t r;
		r.kind   = kind;
		r.pbyte  = pb;
		r.pindex = pi;
		r.ftype  = cur_type;
		r.fid    = fid;
		r.plen   = cur_len;
		expected_events = {expected_events, r};
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] want_sum;
		case (phase)
		PH_WAIT: begin
			if (b == hdr_reg) begin
				cur_type = '0;
				cur_len = '0;
				cur_id = '0;
				pos = '0;
				sum = b;
				phase = PH_USER;
			end
		end
		PH_USER: begin
			if (b == uid_reg) begin
				sum = sum + b;
				phase = PH_TYPE;
			end else
				phase = PH_WAIT;
		end
		PH_TYPE: begin
			sum = sum + b;
			cur_type = b;
			pos = '0;
			phase = PH_LEN;
		end
		PH_LEN: begin
			sum = sum + b;
			if (pos == 0) begin
				cur_len = {8'd0, b};
				pos = 16'd1;
			end else begin
				cur_len[15:8] = b;
				pos = '0;
				if (cur_len > max_len_reg) begin
					queue_event(EV_LEN_FAIL, 8'd0, 16'd0, 16'd0);
					phase = PH_WAIT;
				end else
					phase = PH_ID;
			end
		end
		PH_ID: begin
			sum = sum + b;
			if (pos == 0) begin
				cur_id = {8'd0, b};
				pos = 16'd1;
			end else begin
				cur_id[15:8] = b;
				pos = '0;
				phase = (cur_len == 0) ? PH_SUM : PH_DATA;
			end
		end
		PH_DATA: begin
			sum = sum + b;
			queue_event(EV_PAYLOAD, b, pos, cur_id);
			pos = pos + 16'd1;
			if (pos >= cur_len)
				phase = PH_SUM;
		end
		PH_SUM: begin
			want_sum = 8'd0 - sum;
			queue_event((want_sum == b) ? EV_GOOD : EV_BAD_SUM, 8'd0, 16'd0, cur_id);
			phase = PH_WAIT;
		end
		default: phase = PH_WAIT;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			hdr_reg = HEADER_RESET;
			uid_reg = USER_ID_RESET;
			max_len_reg = MAX_LEN_RESET;
			phase = PH_WAIT;
			cur_type = '0;
			cur_len = '0;
			cur_id = '0;
			pos = '0;
			sum = '0;
			expected_events.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_events.size() == 0)
					flag_mismatch("result item with none expected, event_kind", event_kind, -1);
				else begin
					want = expected_events.pop_front();
					if (event_kind != want.kind)
						flag_mismatch("event_kind", event_kind, want.kind);
					if (payload_byte != want.pbyte)
						flag_mismatch("payload_byte", payload_byte, want.pbyte);
					if (payload_index != want.pindex)
						flag_mismatch("payload_index", payload_index, want.pindex);
					if (frame_type != want.ftype)
						flag_mismatch("frame_type", frame_type, want.ftype);
					if (frame_id != want.fid)
						flag_mismatch("frame_id", frame_id, want.fid);
					if (payload_length != want.plen)
						flag_mismatch("payload_length", payload_length, want.plen);
				end
			end
			if (in_valid && in_ready)
				parse_rx_byte(rx_byte);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_HEADER:  hdr_reg = cfg_data[7:0];
				REG_USER_ID: uid_reg = cfg_data[7:0];
				REG_MAX_LEN: max_len_reg = cfg_data;
				default: ;
				endcase
			end
			outstanding <= expected_events.size();
		end
	end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench top for the serial frame parser: clock, reset, frame and noise stimulus,
// register writes, output back-pressure, watchdog and verdict.
// Depends on sfp_pkg, serial_frame_parser and sfp_frame_checker.
`default_nettype none

module tb_top;
	import sfp_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_BYTES = 190;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  frame_type;
	logic [15:0] frame_id;
	logic [15:0] payload_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int outstanding;
	int results_seen;

	logic [7:0]  hdr_val;
	logic [7:0]  uid_val;
	logic [15:0] max_len_val;
	int          idle_pct;
	int          stall_pct;
	bit          pressure_on;
	int          bytes_sent;
	int          frames_sent;
	int          quiet_cycles;

	serial_frame_parser uut (.*);

	sfp_frame_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
			input logic [15:0] id, input bit bad_sum);
		logic [7:0] fb[$];
		logic [7:0] sum;
		fb = '{hdr_val, uid_val, ftype, len[7:0], len[15:8]};
		if (len <= max_len_val) begin
			fb = {fb, id[7:0]};
			fb = {fb, id[15:8]};
			for (int i = 0; i < len; i++)
				fb = {fb, 8'($urandom)};
			sum = '0;
			foreach (fb[i])
				sum = sum + fb[i];
			sum = 8'd0 - sum;
			fb = {fb, (bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum)};
		end
		foreach (fb[i])
			send_byte(fb[i]);
		frames_sent++;
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		int cap;
		r = $urandom_range(99);
		cap = (max_len_val < 8) ? max_len_val : 8;
		if (r < 5 && max_len_val != 16'hFFFF)
			return max_len_val + 16'd1;
		else if (r < 10 && max_len_val != 16'hFFFF)
			return 16'($urandom_range(65535, max_len_val + 1));
		else if (r < 15 && max_len_val <= 64)
			return max_len_val;
		return 16'($urandom_range(cap, 0));
	endfunction

	task automatic send_random_sequence();
		int pick;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 70)
			send_frame(8'($urandom), pick_length(), 16'($urandom), $urandom_range(3) == 0);
		else if (pick < 80) begin
			send_byte(hdr_val);
			send_byte(uid_val ^ 8'($urandom_range(255, 1)));
		end else begin
			repeat ($urandom_range(4, 1)) begin
				b = 8'($urandom);
				send_byte((b == hdr_val) ? ~b : b);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] h, input logic [7:0] u,
			input logic [15:0] m);
		drain_results();
		write_reg(REG_HEADER, {8'($urandom), h});
		write_reg(REG_USER_ID, {8'($urandom), u});
		write_reg(REG_MAX_LEN, m);
		hdr_val = h;
		uid_val = u;
		max_len_val = m;
	endtask

	// The receiver holds off once for a long stretch so the block fills and stalls input.
	initial begin
		int held;
		held = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_on && held < HOLD_CYCLES) begin
				held++;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("serial_frame_parser: mismatch");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int phase_start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_HEADER;
		cfg_data <= '0;
		pressure_on = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hdr_val = HEADER_RESET;
		uid_val = USER_ID_RESET;
		max_len_val = MAX_LEN_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(hdr_val);
		send_byte(hdr_val);
		send_frame(8'hFF, 16'd0, 16'hFFFF, 1'b0);
		send_frame(8'h00, 16'hFFFF, 16'h0000, 1'b0);
		send_frame(8'h80, 16'd1, 16'h0001, 1'b1);

		// A limit written in the middle of a frame applies to its second length byte.
		send_byte(hdr_val);
		send_byte(uid_val);
		send_byte(8'h12);
		send_byte(8'd5);
		drain_results();
		write_reg(REG_MAX_LEN, 16'd4);
		write_reg(REG_UNUSED, 16'hFFFF);
		max_len_val = 16'd4;
		send_byte(8'd0);

		for (int p = 0; p < 8; p++) begin
			case (p % 5)
			0: apply_settings(HEADER_RESET, USER_ID_RESET, MAX_LEN_RESET);
			1: apply_settings(8'h00, 8'hFF, 16'd0);
			2: apply_settings(8'hFF, 8'h00, 16'hFFFF);
			3: apply_settings(8'($urandom), 8'($urandom), 16'd5);
			default: apply_settings(8'h5A, 8'hA5, 16'd300);
			endcase
			case (p % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 78; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 78; end
			default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			phase_start = bytes_sent;
			if (p == 0) begin
				pressure_on = 1'b1;
				send_frame(8'h3C, 16'd40, 16'h1234, 1'b0);
				send_frame(8'hC3, 16'd300, 16'hBEEF, 1'b0);
			end
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_sequence();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d frames over five register settings and four idle mixes,",
			bytes_sent, frames_sent);
		$display("including a long output hold; %0d result items were checked.", results_seen);
		if (fail_count == 0)
			$display("serial_frame_parser: match");
		else
			$display("serial_frame_parser: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/sfp_pkg.sv
rtl/serial_frame_parser.sv
verif/sfp_frame_checker.sv
verif/tb_top.sv
